// ----- rtl/core/bpfa_pkg.sv -----
// Package for the bitmap page frame allocator: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int NUM_PAGES     = 4096;
  localparam int PAGE_BYTES    = 4096;
  localparam int BITS_PER_BYTE = 8;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int ADDR_W        = 32;
  localparam int PFN_W         = ADDR_W - PAGE_SHIFT;
  localparam int WORD_W        = 64;
  localparam int NUM_WORDS     = NUM_PAGES / WORD_W;
  localparam int WORD_IDX_W    = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W     = $clog2(WORD_W);
  localparam int PAGE_IDX_W    = $clog2(NUM_PAGES);
  localparam int PAGE_CNT_W    = PAGE_IDX_W + 1;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 1;

  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_END = 1'd1;

  typedef struct packed {
    logic                acc;
    logic                init_base;
    logic                init_cnt;
    logic                init_bm;
    logic                init_map;
    logic                al_rd;
    logic                al_bit;
    logic                al_wr;
    logic                fr_sub;
    logic                fr_rd;
    logic                fr_wr;
    logic                out_ld;
    logic [STATUS_W-1:0] out_status;
    logic                out_use_addr;
  } cmd_t;

  typedef struct packed {
    logic sum_any;
    logic below;
    logic unaligned;
    logic out_range;
    logic bit_free;
  } sts_t;

endpackage

// ----- rtl/core/bpfa_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bpfa_dp.sv -----
// Allocator datapath: config registers, base/count, bitmap RAM with row valid bits
// and a per-word summary, free checks and result registers. Uses bpfa_pkg, bpfa_ram.
`timescale 1ns / 1ps

module bpfa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]    in_addr_i,
  input  bpfa_pkg::cmd_t                 cmd_i,
  output bpfa_pkg::sts_t                 sts_o,
  output logic [bpfa_pkg::ADDR_W-1:0]    page_addr_o,
  output logic [bpfa_pkg::STATUS_W-1:0]  status_o
);

  localparam int AW = bpfa_pkg::ADDR_W;
  localparam int WW = bpfa_pkg::WORD_W;
  localparam int CW = bpfa_pkg::PAGE_CNT_W;
  localparam int XW = bpfa_pkg::WORD_IDX_W;
  localparam int BW = bpfa_pkg::BIT_IDX_W;
  localparam int NW = bpfa_pkg::NUM_WORDS;
  localparam int PS = bpfa_pkg::PAGE_SHIFT;
  localparam int FW = bpfa_pkg::PFN_W;

  logic [AW-1:0] kend_q, mend_q;
  logic [AW-1:0] addr_q, base_q, off_q, alloc_addr_q;
  logic [CW-1:0] page_count_q, bm_q;
  logic          below_q;
  logic [NW-1:0] valid_q, summary_q;
  logic [XW-1:0] widx_q;
  logic [BW-1:0] bit_q;
  logic [WW-1:0] word_q;
  logic [AW-1:0] page_addr_q;
  logic [bpfa_pkg::STATUS_W-1:0] status_q;

  logic [AW-1:0] base_sum, cnt_diff, bm_bytes, bm_sum;
  logic [FW-1:0] cnt_pfn;
  logic [CW-1:0] cnt_d;
  logic [NW-1:0] map_summary;
  logic [WW-1:0] dflt_word, cur_word, rdata, clr_word;
  logic [XW-1:0] first_word;
  logic [BW-1:0] first_zero;
  logic [XW-1:0] raddr;
  logic [WW-1:0] wdata;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q <= '0;
      mend_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpfa_pkg::CFG_KERNEL_END: kend_q <= cfg_data_i;
        bpfa_pkg::CFG_MEMORY_END: mend_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // init arithmetic
  always_comb begin
    base_sum = (kend_q + AW'(bpfa_pkg::PAGE_BYTES - 1)) & ~AW'(bpfa_pkg::PAGE_BYTES - 1);
    cnt_diff = mend_q - base_q;
    cnt_pfn  = cnt_diff[AW-1:PS];
    if (mend_q < base_q) begin
      cnt_d = '0;
    end else if (cnt_pfn > FW'(bpfa_pkg::NUM_PAGES)) begin
      cnt_d = CW'(bpfa_pkg::NUM_PAGES);
    end else begin
      cnt_d = cnt_pfn[CW-1:0];
    end
    bm_bytes = (AW'(page_count_q) + AW'(bpfa_pkg::BITS_PER_BYTE - 1)) >>
               $clog2(bpfa_pkg::BITS_PER_BYTE);
    bm_sum   = bm_bytes + AW'(bpfa_pkg::PAGE_BYTES - 1);
  end

  // word w holds a free page iff [bm, count) meets its page span
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      map_summary[w] = (bm_q < CW'((w + 1) * WW)) && (page_count_q > CW'(w * WW)) &&
                       (bm_q < page_count_q);
    end
  end

  // content of a row that has not been written since init
  always_comb begin
    logic [CW-1:0] p;
    for (int j = 0; j < WW; j++) begin
      p = {1'b0, widx_q, BW'(j)};
      dflt_word[j] = (p < bm_q) || (p >= page_count_q);
    end
  end

  assign cur_word = valid_q[widx_q] ? rdata : dflt_word;
  assign clr_word = cur_word & ~(WW'(1) << bit_q);

  always_comb begin
    first_word = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (summary_q[w]) first_word = XW'(w);
    end
    first_zero = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (!cur_word[j]) first_zero = BW'(j);
    end
  end

  assign raddr = cmd_i.fr_rd ? off_q[PS + BW +: XW] : first_word;
  assign wdata = cmd_i.al_wr ? word_q : clr_word;

  bpfa_ram #(
    .WIDTH(WW),
    .DEPTH(NW)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (cmd_i.al_wr | cmd_i.fr_wr),
    .waddr_i(widx_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.al_rd | cmd_i.fr_rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      page_count_q <= '0;
      bm_q         <= '0;
      valid_q      <= '0;
      summary_q    <= '0;
    end else begin
      if (cmd_i.init_base) base_q <= base_sum;
      if (cmd_i.init_cnt)  page_count_q <= cnt_d;
      if (cmd_i.init_bm)   bm_q <= CW'(bm_sum >> PS);
      if (cmd_i.init_map) begin
        valid_q   <= '0;
        summary_q <= map_summary;
      end
      if (cmd_i.al_wr) begin
        valid_q[widx_q]   <= 1'b1;
        summary_q[widx_q] <= ~&word_q;
      end
      if (cmd_i.fr_wr) begin
        valid_q[widx_q]   <= 1'b1;
        summary_q[widx_q] <= 1'b1;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) addr_q <= in_addr_i;
    if (cmd_i.fr_sub) begin
      off_q   <= addr_q - base_q;
      below_q <= addr_q < base_q;
    end
    if (cmd_i.al_rd) widx_q <= first_word;
    if (cmd_i.fr_rd) begin
      widx_q <= off_q[PS + BW +: XW];
      bit_q  <= off_q[PS +: BW];
    end
    if (cmd_i.al_bit) begin
      bit_q  <= first_zero;
      word_q <= cur_word | (WW'(1) << first_zero);
    end
    if (cmd_i.al_wr) alloc_addr_q <= base_q + (AW'({widx_q, bit_q}) << PS);
    if (cmd_i.out_ld) begin
      page_addr_q <= cmd_i.out_use_addr ? alloc_addr_q : '0;
      status_q    <= cmd_i.out_status;
    end
  end

  assign sts_o.sum_any   = |summary_q;
  assign sts_o.below     = below_q;
  assign sts_o.unaligned = off_q[PS-1:0] != '0;
  assign sts_o.out_range = off_q[AW-1:PS] >= FW'(page_count_q);
  assign sts_o.bit_free  = ~cur_word[bit_q];

  assign page_addr_o = page_addr_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/core/bpfa_ctrl.sv -----
// Allocator controller: sequences init, alloc and free over the datapath and
// owns the result valid flag. Uses bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [bpfa_pkg::MODE_W-1:0]  in_mode_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  bpfa_pkg::sts_t               sts_i,
  output bpfa_pkg::cmd_t               cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT_BASE = 4'd1;
  localparam logic [3:0] S_INIT_CNT  = 4'd2;
  localparam logic [3:0] S_INIT_BM   = 4'd3;
  localparam logic [3:0] S_INIT_MAP  = 4'd4;
  localparam logic [3:0] S_AL_FIND   = 4'd5;
  localparam logic [3:0] S_AL_BIT    = 4'd6;
  localparam logic [3:0] S_AL_WR     = 4'd7;
  localparam logic [3:0] S_FR_SUB    = 4'd8;
  localparam logic [3:0] S_FR_CHK    = 4'd9;
  localparam logic [3:0] S_FR_BIT    = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [bpfa_pkg::STATUS_W-1:0] status_q, status_d;
  logic       use_addr_q, use_addr_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    use_addr_d = use_addr_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc  = 1'b1;
          status_d   = bpfa_pkg::ST_OK;
          use_addr_d = 1'b0;
          unique case (in_mode_i)
            bpfa_pkg::MODE_INIT:  state_d = S_INIT_BASE;
            bpfa_pkg::MODE_ALLOC: state_d = S_AL_FIND;
            bpfa_pkg::MODE_FREE:  state_d = S_FR_SUB;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_INIT_BASE: begin
        cmd_o.init_base = 1'b1;
        state_d = S_INIT_CNT;
      end
      S_INIT_CNT: begin
        cmd_o.init_cnt = 1'b1;
        state_d = S_INIT_BM;
      end
      S_INIT_BM: begin
        cmd_o.init_bm = 1'b1;
        state_d = S_INIT_MAP;
      end
      S_INIT_MAP: begin
        cmd_o.init_map = 1'b1;
        state_d = S_DONE;
      end
      S_AL_FIND: begin
        if (!sts_i.sum_any) begin
          status_d = bpfa_pkg::ST_OOM;
          state_d  = S_DONE;
        end else begin
          cmd_o.al_rd = 1'b1;
          state_d = S_AL_BIT;
        end
      end
      S_AL_BIT: begin
        cmd_o.al_bit = 1'b1;
        state_d = S_AL_WR;
      end
      S_AL_WR: begin
        cmd_o.al_wr = 1'b1;
        use_addr_d  = 1'b1;
        state_d     = S_DONE;
      end
      S_FR_SUB: begin
        cmd_o.fr_sub = 1'b1;
        state_d = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (sts_i.below) begin
          status_d = bpfa_pkg::ST_BELOW;
          state_d  = S_DONE;
        end else if (sts_i.unaligned) begin
          status_d = bpfa_pkg::ST_UNALIGNED;
          state_d  = S_DONE;
        end else if (sts_i.out_range) begin
          status_d = bpfa_pkg::ST_RANGE;
          state_d  = S_DONE;
        end else begin
          cmd_o.fr_rd = 1'b1;
          state_d = S_FR_BIT;
        end
      end
      S_FR_BIT: begin
        if (sts_i.bit_free) begin
          status_d = bpfa_pkg::ST_DOUBLE;
        end else begin
          cmd_o.fr_wr = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    cmd_o.out_status   = status_q;
    cmd_o.out_use_addr = use_addr_q;

    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= bpfa_pkg::ST_OK;
      use_addr_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      use_addr_q  <= use_addr_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/bitmap_page_frame_allocator_top.sv -----
// Top level of the bitmap page frame allocator: stream ports, config port,
// controller and datapath. Uses bpfa_pkg, bpfa_ctrl, bpfa_dp.
`timescale 1ns / 1ps

// Usage
//   Request stream (s_axis): tuser carries the mode (init, alloc, free), tdata the
//   page address to free. Result stream (m_axis): tdata is the allocated page
//   address (zero unless an alloc succeeds), tuser the status code.
//   Config port: write kernel end (index 0) and memory end (index 1) while idle;
//   both are sampled only by an init transaction.
// Operation
//   One request at a time. Alloc ends early when out of memory, free when a
//   check fails, and a no-op goes straight to the result. The next request
//   is taken once the result is loaded.
//   Alloc finds the first word with a free page from a 64-bit per-word summary,
//   reads that word from the bitmap RAM (registered read) and picks its lowest
//   zero bit; the RAM read port sets the alloc step count.
//   Init needs no clearing sweep: rows unwritten since init read as their
//   computed initial pattern through a valid bit per row.
// Reset
//   Every page reads as used, zero pages are managed, base and config are zero.
// Backpressure
//   The result sits in an output register; a finished result that cannot be
//   loaded holds the controller until m_axis_tready frees the slot.
module bitmap_page_frame_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] address
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] page_address
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpfa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_addr_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .page_addr_o(m_axis_tdata),
    .status_o   (m_axis_tuser)
  );

`ifndef SYNTH
  // a request transaction always takes the controller out of idle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a request transaction");

  // an error status never comes with a nonzero address
  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != bpfa_pkg::ST_OK) |-> m_axis_tdata == '0)
    else $error("nonzero page address with error status");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == bpfa_pkg::ST_OK ||
                       m_axis_tuser == bpfa_pkg::ST_OOM ||
                       m_axis_tuser == bpfa_pkg::ST_BELOW ||
                       m_axis_tuser == bpfa_pkg::ST_UNALIGNED ||
                       m_axis_tuser == bpfa_pkg::ST_RANGE ||
                       m_axis_tuser == bpfa_pkg::ST_DOUBLE))
    else $error("undefined status code");
`endif

endmodule

// ----- tb/bitmap_page_frame_allocator_top_tb.sv -----
// Self-checking testbench for bitmap_page_frame_allocator_top: a directed step list,
// then random phases, checked against an in-bench allocator predictor or typed expectations.
// Depends on bpfa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_top_tb;
  import bpfa_pkg::*;

  // mode 3 has no name in the package; the block treats it as a no-op
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  localparam logic [31:0] PAGE_MASK    = 32'(PAGE_BYTES - 1);
  localparam int          IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          PHASE_ITEMS  = 40;    // requests after the init of each random phase
  localparam int          DRAIN_CYCLES = 16;    // tail after the last result, well past latency
  localparam int          DIR_REQS     = 25;    // request rows in the directed list
  localparam int          DIR_STEPS_N  = 33;

  typedef struct packed {
    logic [31:0]         page_addr;
    logic [STATUS_W-1:0] status;
  } frame_result_t;

  typedef enum logic [1:0] {STEP_REQ, STEP_KERNEL_END, STEP_MEMORY_END} step_kind_e;

  // one directed step: either a request or a register write (value is the
  // address or the register data); typed rows carry their own expectation
  typedef struct packed {
    step_kind_e          kind;
    logic [MODE_W-1:0]   mode;
    logic [31:0]         value;
    logic                typed;
    logic [31:0]         exp_page;
    logic [STATUS_W-1:0] exp_status;
  } dir_step_t;

  localparam dir_step_t DIR_STEPS [DIR_STEPS_N] = '{
    // nothing managed after reset
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_OOM},
    '{STEP_REQ,        MODE_FREE,  32'h0000_0000, 1'b1, 32'h0, ST_RANGE},
    '{STEP_REQ,        MODE_FREE,  32'h0000_0001, 1'b1, 32'h0, ST_UNALIGNED},
    '{STEP_REQ,        MODE_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_UNALIGNED},
    '{STEP_REQ,        MODE_NOP,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_INIT,  32'h0000_0000, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_OOM},
    // unaligned kernel end -> base 0x0010_1000, ten pages, page 0 holds the bitmap
    '{STEP_KERNEL_END, MODE_INIT,  32'h0010_0001, 1'b0, 32'h0, ST_OK},
    '{STEP_MEMORY_END, MODE_INIT,  32'h0010_B000, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_INIT,  32'h0000_0000, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_2000, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0010_3000, ST_OK},
    '{STEP_REQ,        MODE_FREE,  32'h0010_0000, 1'b1, 32'h0, ST_BELOW},
    '{STEP_REQ,        MODE_FREE,  32'h0010_2004, 1'b1, 32'h0, ST_UNALIGNED},
    '{STEP_REQ,        MODE_FREE,  32'h0010_B000, 1'b1, 32'h0, ST_RANGE},
    '{STEP_REQ,        MODE_FREE,  32'h0010_4000, 1'b1, 32'h0, ST_DOUBLE},
    '{STEP_REQ,        MODE_FREE,  32'h0010_1000, 1'b0, 32'h0, ST_OK},   // bitmap page
    '{STEP_REQ,        MODE_FREE,  32'h0010_2000, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    // all-ones kernel end wraps the base to zero; page count clamps to the maximum
    '{STEP_KERNEL_END, MODE_INIT,  32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{STEP_MEMORY_END, MODE_INIT,  32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_INIT,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_FREE,  32'hFFFF_F000, 1'b1, 32'h0, ST_RANGE},
    // memory end below the base: nothing managed
    '{STEP_KERNEL_END, MODE_INIT,  32'hFFFF_E001, 1'b0, 32'h0, ST_OK},
    '{STEP_MEMORY_END, MODE_INIT,  32'h0000_1000, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_INIT,  32'h0000_0000, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_OOM},
    '{STEP_REQ,        MODE_FREE,  32'h0000_0000, 1'b1, 32'h0, ST_BELOW},
    // a single page, taken by the bitmap itself
    '{STEP_KERNEL_END, MODE_INIT,  32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{STEP_MEMORY_END, MODE_INIT,  32'h0000_1FFF, 1'b0, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_INIT,  32'h0000_0000, 1'b1, 32'h0, ST_OK},
    '{STEP_REQ,        MODE_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_OOM}
  };

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [31:0]          cfg_data_i    = '0;

  // predictor state, mirrors the allocator after every accepted request
  bit            used_map [NUM_PAGES] = '{default: 1'b1};
  logic [31:0]   base_q        = '0;
  int unsigned   page_count_q  = 0;
  logic [31:0]   kernel_end_q  = '0;
  logic [31:0]   memory_end_q  = '0;

  frame_result_t pending_results [$];  // expected results, oldest first
  logic [31:0]   held_pages [$];       // pages handed out since the last init
  frame_result_t oldest_result;

  int err_count    = 0;
  int req_count    = 0;
  int idle_mode    = 0;  // 0: sender light / receiver heavy, 1: swapped, 2: no idling
  int quiet_cycles = 0;

  bitmap_page_frame_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Init: base is the kernel end rounded up to a page (32-bit wrap), count
  // from the memory end clamped to the table size, bitmap pages stay used.
  function automatic void rebuild_bitmap();
    logic [32:0]     rounded;
    longint unsigned pages;
    longint unsigned bm_pages;
    rounded = {1'b0, kernel_end_q} + 33'(PAGE_BYTES - 1);
    base_q  = rounded[31:0] & ~PAGE_MASK;
    if (memory_end_q < base_q) begin
      pages = 0;
    end else begin
      pages = (memory_end_q - base_q) >> PAGE_SHIFT;
    end
    if (pages > NUM_PAGES) begin
      pages = NUM_PAGES;
    end
    page_count_q = int'(pages);
    bm_pages = ((pages + BITS_PER_BYTE - 1) / BITS_PER_BYTE + PAGE_BYTES - 1) / PAGE_BYTES;
    foreach (used_map[i]) begin
      used_map[i] = !(i >= bm_pages && i < pages);
    end
    held_pages.delete();
  endfunction

  function automatic frame_result_t predict_frame_op(input logic [MODE_W-1:0] mode,
                                                     input logic [31:0] addr);
    frame_result_t res;
    logic [31:0]   off;
    int unsigned   idx;
    res = '{page_addr: '0, status: ST_OK};
    case (mode)
      MODE_INIT: begin
        rebuild_bitmap();
      end
      MODE_ALLOC: begin
        // first fit
        res.status = ST_OOM;
        for (int i = 0; i < page_count_q; i++) begin
          if (!used_map[i]) begin
            used_map[i]   = 1'b1;
            res.page_addr = base_q + (32'(i) << PAGE_SHIFT);
            res.status    = ST_OK;
            held_pages.push_back(res.page_addr);
            break;
          end
        end
      end
      MODE_FREE: begin
        // checks in priority order; any failure leaves the map untouched
        if (addr < base_q) begin
          res.status = ST_BELOW;
        end else begin
          off = addr - base_q;
          idx = off >> PAGE_SHIFT;
          if ((off & PAGE_MASK) != 0) begin
            res.status = ST_UNALIGNED;
          end else if (idx >= page_count_q) begin
            res.status = ST_RANGE;
          end else if (!used_map[idx]) begin
            res.status = ST_DOUBLE;
          end else begin
            used_map[idx] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic int sender_idle_pct();
    return (idle_mode == 0) ? 22 : (idle_mode == 1) ? 72 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (idle_mode == 0) ? 72 : (idle_mode == 1) ? 22 : 0;
  endfunction

  // Result side: tready re-drawn every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
  end

  // One request transaction. Must be entered right after the previous
  // acceptance edge so tvalid never lingers over a second rising edge.
  // The expectation is pushed once the transaction is accepted.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [31:0] addr,
                              input logic typed, input frame_result_t typed_result);
    frame_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_frame_op(mode, addr);
    pending_results.push_back(typed ? typed_result : predicted);
    req_count++;
    idle_mode = (req_count < 340) ? 0 : (req_count < 680) ? 1 : 2;
  endtask

  // Drop tvalid and wait until every outstanding result has been taken.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_KERNEL_END) begin
      kernel_end_q = value;
    end else begin
      memory_end_q = value;
    end
  endtask

  // One random phase: new register values, an init, then mostly well-formed
  // alloc/free traffic with some noise. Small page counts dominate so that
  // the pool runs dry and refills often.
  task automatic run_random_phase();
    logic [31:0]       kend;
    logic [31:0]       mend;
    logic [31:0]       rounded;
    logic [31:0]       addr;
    logic [MODE_W-1:0] mode;
    int                pick;
    int                slot;
    case ($urandom_range(9))
      0: begin
        kend = '0;
        mend = '1;
      end
      1: begin
        kend = '1;
        mend = $urandom;
      end
      2: begin
        kend = $urandom;
        mend = $urandom;
      end
      3: begin
        kend = $urandom;
        mend = '0;
      end
      default: begin
        kend    = $urandom;
        rounded = (kend + PAGE_MASK) & ~PAGE_MASK;
        mend    = rounded + ($urandom_range(1, 24) << PAGE_SHIFT)
                + $urandom_range(PAGE_BYTES - 1);
      end
    endcase
    wait_idle();
    write_reg(CFG_KERNEL_END, kend);
    write_reg(CFG_MEMORY_END, mend);
    send_request(MODE_INIT, $urandom, 1'b0, '0);
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(99);
      addr = $urandom;
      mode = MODE_FREE;
      if (pick < 40) begin
        mode = MODE_ALLOC;
      end else if (pick < 65) begin
        // release something we hold; random address if we hold none
        if (held_pages.size() != 0) begin
          slot = $urandom_range(held_pages.size() - 1);
          addr = held_pages[slot];
          held_pages.delete(slot);
        end
      end else if (pick < 78) begin
        // aligned frees inside and just past the range: double frees, range errors
        addr = base_q + ($urandom_range(page_count_q + 1) << PAGE_SHIFT);
      end else if (pick < 86) begin
        // fully random address, mostly rejected
      end else if (pick < 92) begin
        addr = base_q + $urandom_range(3 * PAGE_BYTES);
      end else if (pick < 96) begin
        mode = MODE_INIT;
      end else begin
        mode = MODE_NOP;
      end
      send_request(mode, addr, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $error("unexpected result: page_address %h status %0d", m_axis_tdata, m_axis_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata !== oldest_result.page_addr) begin
          err_count++;
          $error("page_address: expected %h, got %h", oldest_result.page_addr, m_axis_tdata);
        end
        if (m_axis_tuser !== oldest_result.status) begin
          err_count++;
          $error("status: expected %0d, got %0d", oldest_result.status, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed steps; register writes only once the block has drained
    foreach (DIR_STEPS[i]) begin
      case (DIR_STEPS[i].kind)
        STEP_REQ: begin
          send_request(DIR_STEPS[i].mode, DIR_STEPS[i].value, DIR_STEPS[i].typed,
                       '{page_addr: DIR_STEPS[i].exp_page, status: DIR_STEPS[i].exp_status});
        end
        STEP_KERNEL_END: begin
          wait_idle();
          write_reg(CFG_KERNEL_END, DIR_STEPS[i].value);
        end
        default: begin
          wait_idle();
          write_reg(CFG_MEMORY_END, DIR_STEPS[i].value);
        end
      endcase
    end

    while (req_count < DIR_REQS + RANDOM_ITEMS) begin
      run_random_phase();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_dp.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bitmap_page_frame_allocator_top.sv
tb/bitmap_page_frame_allocator_top_tb.sv
